[rtl/core/imudr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imudr_pkg
// Shared types, constants and helpers for the dead-reckoning step block.
// ----------------------------------------------------------------------------
package imudr_pkg;

  localparam int FRAC_BITS = 16;   // fraction bits of values and time
  localparam int DCM_FRAC  = 14;   // fraction bits of matrix entries
  localparam int K_W       = FRAC_BITS + 1;
  localparam int PROD_W    = 66;   // 33 x 33 signed product
  localparam int SUM_W     = 50;   // three 16 x 32 products
  localparam int SAT_W     = 68;

  localparam logic [20:0] GRAVITY_RST  = 21'd631505;
  localparam logic [19:0] DEADBAND_RST = 20'd32768;
  localparam logic [19:0] QNOISE_RST   = 20'd65536;
  localparam logic [19:0] RNOISE_RST   = 20'd65536;
  localparam logic [31:0] VAR_RST      = 32'd32768;

  localparam logic [1:0] REG_GRAVITY  = 2'd0;
  localparam logic [1:0] REG_DEADBAND = 2'd1;
  localparam logic [1:0] REG_QNOISE   = 2'd2;
  localparam logic [1:0] REG_RNOISE   = 2'd3;

  localparam logic FUNC_INIT = 1'b0;

  typedef logic signed [2:0][31:0] accel_vec_t;

  typedef enum logic [3:0] {
    LOP_NONE, LOP_CLEAR, LOP_MAC0, LOP_MAC, LOP_ACC, LOP_RND, LOP_LOAD,
    LOP_MUL_A, LOP_VEL, LOP_MUL_V, LOP_MUL_DV, LOP_POS
  } lane_op_e;

  typedef struct packed {
    lane_op_e   op;
    logic [1:0] col;
  } lane_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_MAC, ST_ACC, ST_RND, ST_KSTART, ST_KWAIT, ST_LOAD,
    ST_MUL_A, ST_VEL, ST_MUL_V, ST_MUL_DV, ST_POS, ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {K_IDLE, K_DIV, K_MUL, K_UPD} kal_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = $signed({{(SAT_W-32){1'b0}}, 32'h7FFF_FFFF});
    lo = $signed({{(SAT_W-32){1'b1}}, 32'h8000_0000});
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return $signed(32'h8000_0000);
    else return v[31:0];
  endfunction

endpackage

[rtl/core/imudr_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imudr_lane
// One navigation axis: matrix row product, velocity and position update.
// ----------------------------------------------------------------------------
module imudr_lane (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imudr_pkg::lane_ctrl_t ctrl_i,
  input  logic [47:0]          dcm_row_i,
  input  imudr_pkg::accel_vec_t accel_i,
  input  logic [31:0]          dt_i,
  input  logic [20:0]          sub_i,
  input  logic signed [31:0]   load_i,
  output logic signed [31:0]   a_o,
  output logic signed [31:0]   pos_o
);
  import imudr_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [31:0]       a_q, dv_q, vel_q, pos_q;
  logic signed [PROD_W-1:0] t1_q;
  logic signed [32:0]       op_a, op_b;
  logic signed [15:0]       coef;
  logic signed [SUM_W-1:0]  shifted;
  logic signed [31:0]       a_rnd, dv_new;

  always_comb begin
    coef = $signed(dcm_row_i[{ctrl_i.col, 4'b0000} +: 16]);
    op_a = $signed({1'b0, dt_i});
    op_b = {a_q[31], a_q};
    case (ctrl_i.op)
      LOP_MAC0, LOP_MAC: begin
        op_a = 33'(coef);
        // element select of a packed array is unsigned: extend the sign by hand
        op_b = $signed({accel_i[ctrl_i.col][31], accel_i[ctrl_i.col]});
      end
      LOP_MUL_V:  op_b = {vel_q[31], vel_q};
      LOP_MUL_DV: op_b = {dv_q[31], dv_q};
      default:    op_b = {a_q[31], a_q};
    endcase
    shifted = sum_q >>> DCM_FRAC;
    a_rnd   = sat32(SAT_W'(sat32(SAT_W'(shifted))) - SAT_W'($signed({1'b0, sub_i})));
    dv_new  = sat32(SAT_W'(prod_q >>> FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      LOP_MAC0: begin
        prod_q <= op_a * op_b;
        sum_q  <= '0;
      end
      LOP_MAC: begin
        prod_q <= op_a * op_b;
        sum_q  <= sum_q + prod_q[SUM_W-1:0];
      end
      LOP_ACC:   sum_q <= sum_q + prod_q[SUM_W-1:0];
      LOP_RND:   a_q <= a_rnd;
      LOP_LOAD:  a_q <= load_i;
      LOP_MUL_A, LOP_MUL_V: prod_q <= op_a * op_b;
      LOP_VEL:   dv_q <= dv_new;
      LOP_MUL_DV: begin
        t1_q   <= prod_q >>> FRAC_BITS;
        prod_q <= op_a * op_b;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
      pos_q <= '0;
    end else begin
      case (ctrl_i.op)
        LOP_CLEAR: begin
          vel_q <= '0;
          pos_q <= '0;
        end
        LOP_VEL: vel_q <= sat32(SAT_W'(vel_q) + SAT_W'(dv_new));
        LOP_POS: pos_q <= sat32(SAT_W'(pos_q) + SAT_W'(t1_q)
                                + SAT_W'(prod_q >>> (FRAC_BITS + 1)));
        default: ;
      endcase
    end
  end

  assign a_o   = a_q;
  assign pos_o = pos_q;

endmodule

[rtl/core/imudr_kalman.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imudr_kalman
// Deadband and scalar Kalman step on x, with a bit-serial gain divider.
// ----------------------------------------------------------------------------
module imudr_kalman (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] ax_i,
  input  logic [19:0]        deadband_i,
  input  logic [19:0]        qnoise_i,
  input  logic [19:0]        rnoise_i,
  output logic               done_o,
  output logic signed [31:0] est_o
);
  import imudr_pkg::*;

  localparam logic [K_W-1:0] ONE = K_W'(1) << FRAC_BITS;

  kal_state_e state_q, state_d;
  logic [$clog2(FRAC_BITS+1)-1:0] cnt_q;
  logic signed [31:0] x_q, meas_q;
  logic [31:0]        p_q;
  logic [32:0]        pp_q;
  logic [33:0]        den_q, rem_q;
  logic [K_W-1:0]     quo_q;
  logic               zero_q;
  logic signed [50:0] prodx_q;
  logic [49:0]        prodp_q;

  logic [32:0] pp;
  logic [33:0] den;
  logic [32:0] mag;
  logic [34:0] rem2;
  logic        take;
  logic [K_W-1:0] k;
  logic signed [32:0] diff;
  logic [33:0] p_new;

  always_comb begin
    pp   = {1'b0, p_q} + 33'(qnoise_i);
    den  = {1'b0, pp} + 34'(rnoise_i);
    mag  = ax_i[31] ? -{ax_i[31], ax_i} : {1'b0, ax_i};
    rem2 = {rem_q, 1'b0};
    take = rem2 >= {1'b0, den_q};
    k    = zero_q ? '0 : quo_q;
    diff = {meas_q[31], meas_q} - {x_q[31], x_q};
    p_new = 34'(prodp_q >> FRAC_BITS);
    state_d = state_q;
    done_o  = 1'b0;
    unique case (state_q)
      K_IDLE: if (start_i) state_d = K_DIV;
      K_DIV:  if (cnt_q == 1) state_d = K_MUL;
      K_MUL:  state_d = K_UPD;
      K_UPD: begin
        state_d = K_IDLE;
        done_o  = 1'b1;
      end
      default: state_d = K_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      K_IDLE: if (start_i) begin
        meas_q <= (mag <= 33'(deadband_i)) ? '0 : ax_i;
        pp_q   <= pp;
        den_q  <= den;
        zero_q <= (den == '0);
        if ({1'b0, pp} >= den) begin
          rem_q <= {1'b0, pp} - den;
          quo_q <= K_W'(1);
        end else begin
          rem_q <= {1'b0, pp};
          quo_q <= '0;
        end
      end
      K_DIV: begin
        rem_q <= take ? 34'(rem2 - {1'b0, den_q}) : rem2[33:0];
        quo_q <= {quo_q[K_W-2:0], take};
      end
      K_MUL: begin
        prodx_q <= $signed({1'b0, k}) * diff;
        prodp_q <= (ONE - k) * pp_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= K_IDLE;
      cnt_q   <= '0;
      x_q     <= '0;
      p_q     <= VAR_RST;
    end else begin
      state_q <= state_d;
      if (state_q == K_IDLE) cnt_q <= ($clog2(FRAC_BITS+1))'(FRAC_BITS);
      else if (state_q == K_DIV) cnt_q <= cnt_q - 1'b1;
      if (state_q == K_UPD) begin
        x_q <= sat32(SAT_W'(x_q) + SAT_W'(prodx_q >>> FRAC_BITS));
        p_q <= (p_new > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : p_new[31:0];
      end
    end
  end

  assign est_o = x_q;

endmodule

[rtl/core/imu_dead_reckoning_step_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_dead_reckoning_step_top
// Strapdown dead-reckoning step: rotate, filter x, integrate, give position.
// ----------------------------------------------------------------------------
// One word in, one position word out. An update word passes through three
// matrix products per axis on the lane multipliers plus accumulate and
// round, filter start, the Kalman unit (set-up, 16-step serial divide,
// multiply, update), then load, the multiply/update steps per axis for
// velocity and position, and the output state. An init word clears the
// lanes and goes to the output state. One word is worked at a time; the
// next is taken once the last result sits in the output register, which
// holds it while out_stall_i is high. Three axis lanes run side by side,
// each with one 33x33 multiplier; the x lane value is replaced by the
// filter estimate before integration.
// Registers (APB, byte address 4*i): gravity_z, deadband, process_noise,
// measure_noise. pready is tied high; writes belong to idle periods.
// ----------------------------------------------------------------------------
module imu_dead_reckoning_step_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [47:0] dcm_row0_i,
  input  logic [47:0] dcm_row1_i,
  input  logic [47:0] dcm_row2_i,
  input  logic signed [31:0] accel_x_i,
  input  logic signed [31:0] accel_y_i,
  input  logic signed [31:0] accel_z_i,
  input  logic [31:0] timestamp_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o
);
  import imudr_pkg::*;

  top_state_e state_q, state_d;
  logic [1:0]  cnt_q;
  logic [20:0] gravity_q;
  logic [19:0] deadband_q, qnoise_q, rnoise_q;
  logic [31:0] last_time_q, dt_q;
  logic [2:0][47:0] dcm_q;
  accel_vec_t  accel_q;
  logic        out_valid_q;
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;

  lane_ctrl_t ctrl [3];
  lane_op_e   lop;
  logic       kal_start, kal_done;
  logic signed [31:0] kal_est;
  logic signed [31:0] a_lane [3];
  logic signed [31:0] pos_lane [3];
  logic       accept, out_free;

  assign pready     = 1'b1;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_q  <= GRAVITY_RST;
      deadband_q <= DEADBAND_RST;
      qnoise_q   <= QNOISE_RST;
      rnoise_q   <= RNOISE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_GRAVITY:  gravity_q  <= pwdata[20:0];
        REG_DEADBAND: deadband_q <= pwdata[19:0];
        REG_QNOISE:   qnoise_q   <= pwdata[19:0];
        REG_RNOISE:   rnoise_q   <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRAVITY:  prdata = {11'b0, gravity_q};
      REG_DEADBAND: prdata = {12'b0, deadband_q};
      REG_QNOISE:   prdata = {12'b0, qnoise_q};
      REG_RNOISE:   prdata = {12'b0, rnoise_q};
      default:      prdata = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    lop       = LOP_NONE;
    kal_start = 1'b0;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = (func_i == FUNC_INIT) ? ST_CLEAR : ST_MAC;
      ST_CLEAR: begin
        lop     = LOP_CLEAR;
        state_d = ST_OUT;
      end
      ST_MAC: begin
        lop = (cnt_q == 2'd0) ? LOP_MAC0 : LOP_MAC;
        if (cnt_q == 2'd2) state_d = ST_ACC;
      end
      ST_ACC: begin
        lop     = LOP_ACC;
        state_d = ST_RND;
      end
      ST_RND: begin
        lop     = LOP_RND;
        state_d = ST_KSTART;
      end
      ST_KSTART: begin
        kal_start = 1'b1;
        state_d   = ST_KWAIT;
      end
      ST_KWAIT: if (kal_done) state_d = ST_LOAD;
      ST_LOAD: begin
        lop     = LOP_LOAD;
        state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        lop     = LOP_MUL_A;
        state_d = ST_VEL;
      end
      ST_VEL: begin
        lop     = LOP_VEL;
        state_d = ST_MUL_V;
      end
      ST_MUL_V: begin
        lop     = LOP_MUL_V;
        state_d = ST_MUL_DV;
      end
      ST_MUL_DV: begin
        lop     = LOP_MUL_DV;
        state_d = ST_POS;
      end
      ST_POS: begin
        lop     = LOP_POS;
        state_d = ST_OUT;
      end
      ST_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    for (int i = 0; i < 3; i++) begin
      ctrl[i].op  = lop;
      ctrl[i].col = cnt_q;
    end
    // only the x lane takes the filter estimate
    if (lop == LOP_LOAD) begin
      ctrl[1].op = LOP_NONE;
      ctrl[2].op = LOP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= (state_q == ST_MAC) ? cnt_q + 2'd1 : 2'd0;
      if (accept) last_time_q <= timestamp_i;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q       <= timestamp_i - last_time_q;
      dcm_q      <= {dcm_row2_i, dcm_row1_i, dcm_row0_i};
      accel_q[0] <= accel_x_i;
      accel_q[1] <= accel_y_i;
      accel_q[2] <= accel_z_i;
    end
    if (state_q == ST_OUT && out_free) begin
      pos_x_q <= pos_lane[0];
      pos_y_q <= pos_lane[1];
      pos_z_q <= pos_lane[2];
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    imudr_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[g]),
      .dcm_row_i (dcm_q[g]),
      .accel_i   (accel_q),
      .dt_i      (dt_q),
      .sub_i     ((g == 2) ? gravity_q : 21'd0),
      .load_i    (kal_est),
      .a_o       (a_lane[g]),
      .pos_o     (pos_lane[g])
    );
  end

  imudr_kalman u_kalman (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (kal_start),
    .ax_i       (a_lane[0]),
    .deadband_i (deadband_q),
    .qnoise_i   (qnoise_q),
    .rnoise_i   (rnoise_q),
    .done_o     (kal_done),
    .est_o      (kal_est)
  );

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign pos_z_o     = pos_z_q;

endmodule

[tb/sv/imu_dead_reckoning_step_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_dead_reckoning_step_top_tb
// Self-checking bench for the strapdown dead-reckoning step block.
// ----------------------------------------------------------------------------
// A short directed table (init, zero time step, deadband edges, matrix and
// acceleration extremes, time going backward, wrap) is followed by random
// words, mostly well-formed update runs with small time steps. Each accepted
// word is run through an in-bench predictor of the block; every position word
// that comes out is checked against the oldest prediction. Phases differ in
// register settings and in how often the sender idles and the receiver stalls.
// ----------------------------------------------------------------------------
module imu_dead_reckoning_step_top_tb;
  import imudr_pkg::*;

  typedef struct {
    logic        func;
    logic [47:0] row0;
    logic [47:0] row1;
    logic [47:0] row2;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic [31:0] ts;
  } imu_word_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_word_t;

  // directed row: word, whether the result is typed in, and that result
  typedef struct {
    imu_word_t w;
    bit        typed;
    pos_word_t p;
  } dir_row_t;

  localparam logic [47:0] ROW_X   = 48'h0000_0000_4000;
  localparam logic [47:0] ROW_Y   = 48'h0000_4000_0000;
  localparam logic [47:0] ROW_Z   = 48'h4000_0000_0000;
  localparam logic [47:0] ROW_MAX = 48'h7FFF_7FFF_7FFF;
  localparam logic [47:0] ROW_MIN = 48'h8000_8000_8000;
  localparam logic [47:0] ROW_MIX = 48'h8000_7FFF_8000;
  localparam logic signed [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam logic signed [31:0] S_MIN = 32'h8000_0000;
  localparam pos_word_t ZERO_POS = '{32'sd0, 32'sd0, 32'sd0};
  localparam int NUM_PHASES = 5;
  localparam int RAND_PER_PHASE = 310;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = FUNC_INIT;
  logic [47:0] dcm_row0_i = '0, dcm_row1_i = '0, dcm_row2_i = '0;
  logic signed [31:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic [31:0] timestamp_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, pos_z_o;

  imu_dead_reckoning_step_top uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  logic [20:0] cfg_gravity;
  logic [19:0] cfg_deadband, cfg_qnoise, cfg_rnoise;
  logic [31:0] nav_last_time;
  logic signed [31:0] nav_vel [3];
  logic signed [31:0] nav_pos [3];
  logic signed [31:0] kf_est;
  logic [31:0] kf_var;

  pos_word_t pos_expected [$];
  int  mismatches = 0;
  bit  sender_idles = 1'b0;
  bit  receiver_stalls = 1'b0;
  int  sender_pct = 77;
  int  receiver_pct = 77;
  int  long_holds_asked = 0;
  int  long_holds_done = 0;
  int  hold_left = 0;
  logic [31:0] rand_ts = '0;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return S_MAX;
    if (v < -64'sd2147483648) return S_MIN;
    return v[31:0];
  endfunction

  // Kalman filter on the x acceleration; updates estimate and variance
  function automatic logic signed [31:0] kalman_x(logic signed [31:0] meas);
    longint pp, den, k, diff, p;
    pp = longint'(kf_var) + longint'(cfg_qnoise);
    den = pp + longint'(cfg_rnoise);
    k = (den != 0) ? (pp <<< FRAC_BITS) / den : 0;
    if (k > (64'sd1 <<< FRAC_BITS)) k = 64'sd1 <<< FRAC_BITS;
    diff = longint'(meas) - longint'(kf_est);
    kf_est = clip32(longint'(kf_est) + ((k * diff) >>> FRAC_BITS));
    p = (((64'sd1 <<< FRAC_BITS) - k) * pp) >>> FRAC_BITS;
    kf_var = (p > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    return kf_est;
  endfunction

  // one step of dead reckoning; returns the position word
  function automatic pos_word_t dead_reckon_step(imu_word_t w);
    logic [47:0] rows [3];
    longint acc_b [3];
    logic signed [31:0] acc_n [3];
    longint sum, dt, mag, t1, t2;
    logic [31:0] delta;
    logic signed [31:0] dv;
    pos_word_t r;
    rows[0] = w.row0; rows[1] = w.row1; rows[2] = w.row2;
    if (w.func == FUNC_INIT) begin
      nav_last_time = w.ts;
      for (int i = 0; i < 3; i++) begin
        nav_vel[i] = '0;
        nav_pos[i] = '0;
      end
    end else begin
      delta = w.ts - nav_last_time;
      dt = longint'(delta);
      acc_b[0] = w.ax; acc_b[1] = w.ay; acc_b[2] = w.az;
      for (int i = 0; i < 3; i++) begin
        sum = 0;
        for (int j = 0; j < 3; j++)
          sum += longint'($signed(rows[i][16*j +: 16])) * acc_b[j];
        acc_n[i] = clip32(sum >>> DCM_FRAC);
      end
      acc_n[2] = clip32(longint'(acc_n[2]) - longint'(cfg_gravity));
      mag = (acc_n[0] < 0) ? -longint'(acc_n[0]) : longint'(acc_n[0]);
      if (mag <= longint'(cfg_deadband)) acc_n[0] = '0;
      acc_n[0] = kalman_x(acc_n[0]);
      for (int i = 0; i < 3; i++) begin
        dv = clip32((dt * longint'(acc_n[i])) >>> FRAC_BITS);
        nav_vel[i] = clip32(longint'(nav_vel[i]) + longint'(dv));
        t1 = (dt * longint'(nav_vel[i])) >>> FRAC_BITS;
        t2 = (dt * longint'(dv)) >>> (FRAC_BITS + 1);
        nav_pos[i] = clip32(longint'(nav_pos[i]) + t1 + t2);
      end
      nav_last_time = w.ts;
    end
    r.x = nav_pos[0]; r.y = nav_pos[1]; r.z = nav_pos[2];
    return r;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_GRAVITY:  cfg_gravity  = val[20:0];
      REG_DEADBAND: cfg_deadband = val[19:0];
      REG_QNOISE:   cfg_qnoise   = val[19:0];
      REG_RNOISE:   cfg_rnoise   = val[19:0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    while (pos_expected.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // offer one word, hold it until taken; the prediction is made on acceptance
  task automatic offer_word(imu_word_t w, bit typed, pos_word_t typed_pos);
    pos_word_t p;
    while (sender_idles && $urandom_range(99) < sender_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= w.func;
    dcm_row0_i <= w.row0; dcm_row1_i <= w.row1; dcm_row2_i <= w.row2;
    accel_x_i <= w.ax; accel_y_i <= w.ay; accel_z_i <= w.az;
    timestamp_i <= w.ts;
    do @(posedge clk_i); while (in_stall_o);
    p = dead_reckon_step(w);
    pos_expected.push_back(typed ? typed_pos : p);
  endtask

  function automatic logic [47:0] rand_row(bit wide);
    logic [47:0] r;
    for (int j = 0; j < 3; j++)
      r[16*j +: 16] = wide ? 16'($urandom) : 16'($urandom_range(32768) - 16384);
    return r;
  endfunction

  // mostly short well-formed update runs, some inits, some raw noise
  function automatic imu_word_t rand_word();
    imu_word_t w;
    int pick;
    pick = $urandom_range(99);
    w.func = (pick < 8) ? FUNC_INIT : 1'b1;
    if (pick < 88) begin
      w.row0 = rand_row(1'b0); w.row1 = rand_row(1'b0); w.row2 = rand_row(1'b0);
      w.ax = $signed($urandom_range(8388608)) - 32'sd4194304;
      w.ay = $signed($urandom_range(8388608)) - 32'sd4194304;
      w.az = $signed($urandom_range(8388608)) - 32'sd4194304 + 32'sd631505;
      rand_ts = rand_ts + $urandom_range(2000);
      w.ts = rand_ts;
    end else begin
      w.row0 = rand_row(1'b1); w.row1 = rand_row(1'b1); w.row2 = rand_row(1'b1);
      w.ax = $urandom; w.ay = $urandom; w.az = $urandom;
      w.ts = $urandom;
      rand_ts = w.ts;
    end
    return w;
  endfunction

  // receiver stall; a long hold is asked for by the stimulus, counted here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (long_holds_done < long_holds_asked) begin
      out_stall_i <= 1'b1;
      hold_left <= 400;
      long_holds_done <= long_holds_done + 1;
    end else begin
      out_stall_i <= receiver_stalls ? ($urandom_range(99) < receiver_pct) : 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pos_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pos_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected position word %0d %0d %0d", pos_x_o, pos_y_o, pos_z_o);
      end else begin
        e = pos_expected.pop_front();
        if (pos_x_o !== e.x || pos_y_o !== e.y || pos_z_o !== e.z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("position mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     e.x, e.y, e.z, pos_x_o, pos_y_o, pos_z_o);
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    dir_row_t dir_tab [] = '{
      // init, then a zero time step: position stays zero
      '{'{FUNC_INIT, ROW_X, ROW_Y, ROW_Z, 32'sd0, 32'sd0, 32'sd0, 32'd100}, 1'b1, ZERO_POS},
      '{'{1'b1, ROW_X, ROW_Y, ROW_Z, 32'sd0, 32'sd0, 32'sd0, 32'd100}, 1'b1, ZERO_POS},
      '{'{1'b1, ROW_X, ROW_Y, ROW_Z, 32'sd65536, 32'sd0, 32'sd631505, 32'd65636},
        1'b0, ZERO_POS},
      // deadband edges on x
      '{'{1'b1, ROW_X, ROW_Y, ROW_Z, 32'sd32768, 32'sd1, 32'sd0, 32'd131172}, 1'b0, ZERO_POS},
      '{'{1'b1, ROW_X, ROW_Y, ROW_Z, -32'sd32768, 32'sd0, 32'sd0, 32'd131200}, 1'b0, ZERO_POS},
      '{'{1'b1, ROW_X, ROW_Y, ROW_Z, 32'sd32769, 32'sd0, 32'sd0, 32'd135000}, 1'b0, ZERO_POS},
      '{'{1'b1, ROW_X, ROW_Y, ROW_Z, -32'sd32769, 32'sd0, 32'sd0, 32'd140000}, 1'b0, ZERO_POS},
      // matrix and acceleration extremes, saturating
      '{'{1'b1, ROW_MAX, ROW_MAX, ROW_MAX, S_MAX, S_MAX, S_MAX, 32'd200000}, 1'b0, ZERO_POS},
      '{'{1'b1, ROW_MIN, ROW_MIN, ROW_MIN, S_MIN, S_MIN, S_MIN, 32'd200100}, 1'b0, ZERO_POS},
      '{'{1'b1, ROW_MIX, ROW_MAX, ROW_MIN, S_MIN, S_MAX, S_MIN, 32'd200200}, 1'b0, ZERO_POS},
      '{'{1'b1, ROW_MIN, ROW_MIX, ROW_MAX, S_MAX, S_MIN, S_MAX, 32'd300000}, 1'b0, ZERO_POS},
      // time going backward reads as a long step
      '{'{1'b1, ROW_X, ROW_Y, ROW_Z, 32'sd100000, -32'sd5, 32'sd700000, 32'd50}, 1'b0, ZERO_POS},
      // init at the top of the clock, then wrap over zero; filter is kept
      '{'{FUNC_INIT, ROW_MAX, ROW_MIN, ROW_MIX, S_MAX, S_MIN, S_MAX, 32'hFFFF_FFFF},
        1'b1, ZERO_POS},
      '{'{1'b1, ROW_X, ROW_Y, ROW_Z, 32'sd200000, 32'sd65536, 32'sd0, 32'h0000_FFFF},
        1'b0, ZERO_POS},
      '{'{1'b1, ROW_Z, ROW_X, ROW_Y, -32'sd300000, 32'sd1, -32'sd1, 32'h8000_0000},
        1'b0, ZERO_POS},
      '{'{FUNC_INIT, ROW_X, ROW_Y, ROW_Z, 32'sd0, 32'sd0, 32'sd0, 32'd0}, 1'b1, ZERO_POS}
    };

    // reset values of the predictor
    cfg_gravity = GRAVITY_RST; cfg_deadband = DEADBAND_RST;
    cfg_qnoise = QNOISE_RST; cfg_rnoise = RNOISE_RST;
    nav_last_time = '0;
    for (int i = 0; i < 3; i++) begin
      nav_vel[i] = '0;
      nav_pos[i] = '0;
    end
    kf_est = '0; kf_var = VAR_RST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[n]) offer_word(dir_tab[n].w, dir_tab[n].typed, dir_tab[n].p);
    in_valid_i <= 1'b0;
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // register settings per phase: reset values, maxima, minima, random
      case (ph)
        1: begin
          reg_write(REG_GRAVITY, 32'd1310720); reg_write(REG_DEADBAND, 32'd655360);
          reg_write(REG_QNOISE, 32'd655360);   reg_write(REG_RNOISE, 32'd655360);
        end
        2: begin
          reg_write(REG_GRAVITY, 32'd0); reg_write(REG_DEADBAND, 32'd0);
          reg_write(REG_QNOISE, 32'd1);  reg_write(REG_RNOISE, 32'd1);
        end
        3, 4: begin
          reg_write(REG_GRAVITY, $urandom_range(1310720));
          reg_write(REG_DEADBAND, $urandom_range(655360));
          reg_write(REG_QNOISE, $urandom_range(655360, 1));
          reg_write(REG_RNOISE, $urandom_range(655360, 1));
        end
        default: ;
      endcase
      // phase 3 idles both sides, each at a chance of 19 in a hundred
      sender_idles    = (ph == 1) || (ph == 3);
      receiver_stalls = (ph == 2) || (ph == 3);
      sender_pct      = (ph == 3) ? 19 : 77;
      receiver_pct    = (ph == 3) ? 19 : 77;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 0 && n == 50) long_holds_asked++;
        if (ph == 0 && n == 150) begin
          in_valid_i <= 1'b0;
          while (pos_expected.size() != 0) @(posedge clk_i);
        end
        offer_word(rand_word(), 1'b0, ZERO_POS);
      end
      in_valid_i <= 1'b0;
      drain_results();
    end

    if (mismatches == 0 && pos_expected.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
